// File: rtl/jdcc_pkg.sv
// shared types, constants and codes for the joystick drive command conditioner
// no dependencies; imported by every module of the block
`default_nettype none

package jdcc_pkg;

  // default axis full scale
  localparam int unsigned AXIS_FULL_SCALE_DEF = 32768;

  // percent multiplier and clamp limits
  localparam int unsigned PCT_SCALE   = 100;
  localparam int unsigned PCT_LIMIT   = 100;
  localparam int unsigned VERT_LIMIT  = 50;
  localparam int unsigned VERT_OFFSET = 50;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BTN_R_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BTN_Z_DOWN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BTN_LIGHT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BTN_Z_UP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 3'd5;

  localparam logic [4:0]  RST_BTN_R_ENABLE     = 5'd0;
  localparam logic [4:0]  RST_BTN_Z_DOWN       = 5'd1;
  localparam logic [4:0]  RST_BTN_LIGHT        = 5'd2;
  localparam logic [4:0]  RST_BTN_Z_UP         = 5'd3;
  localparam logic [14:0] RST_DEAD_ZONE        = 15'd4000;
  localparam logic [15:0] RST_CHANGE_THRESHOLD = 16'd400;

  // event modes
  localparam logic [1:0] MODE_AXIS    = 2'd0;
  localparam logic [1:0] MODE_PRESS   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // vertical direction codes (two's complement -1, 0, +1)
  localparam logic [1:0] DIR_STOP = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  // result kinds
  localparam logic KIND_DRIVE  = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  typedef struct packed {
    logic [4:0]  btn_r_enable;
    logic [4:0]  btn_z_down;
    logic [4:0]  btn_light;
    logic [4:0]  btn_z_up;
    logic [14:0] dead_zone;
    logic [15:0] change_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] axis_r;
    logic [3:0]         hat_pos;
    logic [4:0]         button_id;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [7:0]  cmd_x;
    logic signed [7:0]  cmd_y;
    logic signed [7:0]  cmd_z;
    logic signed [7:0]  cmd_r;
    logic [3:0]         cam_cmd;
    logic               light_cmd;
    logic [4:0]         button_code;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic signed [15:0] last_z;
    logic signed [15:0] last_r;
    logic [1:0]         vertical_dir;
    logic               light_on;
    logic               rot_enabled;
  } state_t;

endpackage

`default_nettype wire

// File: rtl/joystick_drive_command_conditioner_core.sv
// top level of the joystick drive command conditioner
// depends on jdcc_pkg, jdcc_cfg_regs, jdcc_scale and jdcc_event
//
//   channel | direction | ports                    | word
//   --------+-----------+--------------------------+------------------------------------
//   in_     | sink      | tvalid tready tdata tuser| joystick event (axes, hat, button)
//   out_    | source    | tvalid tready tdata tuser| drive command or button code
//   cfg_    | sink      | we index wdata           | one register per write
//
// one word per cycle sustained while the output is not stalled; each word is held in the
// input register and its result is registered into the output register
// the event logic between the two registers sets the rate: one decode and one
// constant multiply per axis
// reset clears valid flags, stored axes, vertical direction, light and rotation enable
// a stalled output holds the input register, also for events that give no result
`default_nettype none

module joystick_drive_command_conditioner_core #(
  parameter int unsigned AXIS_FULL_SCALE = jdcc_pkg::AXIS_FULL_SCALE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input events
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [79:0]                     in_tdata,   // axis_x, axis_y, axis_z, axis_r,
                                                      // hat_pos, button_id, zero pad
  input  logic [1:0]                      in_tuser,   // mode
  // results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,  // cmd_x, cmd_y, cmd_z, cmd_r,
                                                      // cam_cmd, light_cmd, button_code, pad
  output logic [0:0]                      out_tuser,  // kind
  // configuration
  input  logic                            cfg_we,
  input  logic [jdcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jdcc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import jdcc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  logic      s1_go;
  state_t    st_r;
  state_t    st_nxt;
  logic      emit;
  out_item_t res;
  out_item_t out_item_r;
  logic      out_valid_r;

  jdcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // unpack the event word
  always_comb begin
    in_item.mode      = in_tuser;
    in_item.axis_x    = $signed(in_tdata[15:0]);
    in_item.axis_y    = $signed(in_tdata[31:16]);
    in_item.axis_z    = $signed(in_tdata[47:32]);
    in_item.axis_r    = $signed(in_tdata[63:48]);
    in_item.hat_pos   = in_tdata[67:64];
    in_item.button_id = in_tdata[72:68];
  end

  // input stage moves on whenever the output register is free or draining
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= in_item;
    end
  end

  jdcc_event #(.AXIS_FULL_SCALE(AXIS_FULL_SCALE)) u_event (
    .item   (s1_item_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt),
    .emit   (emit),
    .res    (res)
  );

  // block state commits together with the word that changes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_go) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_item_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_item_r.kind;
  assign out_tdata  = {6'd0,
                       out_item_r.button_code,
                       out_item_r.light_cmd,
                       out_item_r.cam_cmd,
                       out_item_r.cmd_r,
                       out_item_r.cmd_z,
                       out_item_r.cmd_y,
                       out_item_r.cmd_x};

  // pad bits of the event word carry nothing
  logic unused_pad;
  assign unused_pad = ^in_tdata[79:73];

endmodule

`default_nettype wire

// File: rtl/jdcc_cfg_regs.sv
// configuration register file, write only
// depends on jdcc_pkg
`default_nettype none

module jdcc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [jdcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jdcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output jdcc_pkg::cfg_t                  cfg
);
  import jdcc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.btn_r_enable     <= RST_BTN_R_ENABLE;
      cfg_r.btn_z_down       <= RST_BTN_Z_DOWN;
      cfg_r.btn_light        <= RST_BTN_LIGHT;
      cfg_r.btn_z_up         <= RST_BTN_Z_UP;
      cfg_r.dead_zone        <= RST_DEAD_ZONE;
      cfg_r.change_threshold <= RST_CHANGE_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BTN_R_ENABLE:     cfg_r.btn_r_enable     <= cfg_wdata[4:0];
        REG_BTN_Z_DOWN:       cfg_r.btn_z_down       <= cfg_wdata[4:0];
        REG_BTN_LIGHT:        cfg_r.btn_light        <= cfg_wdata[4:0];
        REG_BTN_Z_UP:         cfg_r.btn_z_up         <= cfg_wdata[4:0];
        REG_DEAD_ZONE:        cfg_r.dead_zone        <= cfg_wdata[14:0];
        REG_CHANGE_THRESHOLD: cfg_r.change_threshold <= cfg_wdata[15:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/jdcc_scale.sv
// signed axis to clamped percent: value * 100 / DIVISOR, truncated toward zero
// depends on jdcc_pkg; the divide is a constant reciprocal multiply
`default_nettype none

module jdcc_scale #(
  parameter int unsigned DIVISOR = jdcc_pkg::AXIS_FULL_SCALE_DEF,
  parameter int unsigned LIMIT   = jdcc_pkg::PCT_LIMIT
) (
  input  logic signed [15:0] value,
  output logic [16:0]        mag,
  output logic signed [7:0]  pct
);
  import jdcc_pkg::*;

  // 100 * |value| stays below 2^NUM_W
  localparam int unsigned NUM_W  = 22;
  localparam int unsigned DIV_L  = $clog2(DIVISOR);
  localparam int unsigned SHIFT  = NUM_W + DIV_L;
  // rounded-up reciprocal gives an exact floor for every numerator below 2^NUM_W
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam longint unsigned MULT  = RECIP * PCT_SCALE;
  localparam int unsigned MULT_W = $clog2(MULT + 1);
  localparam int unsigned PROD_W = 17 + MULT_W;

  localparam logic [PROD_W-1:0] MULT_C  = PROD_W'(MULT);
  localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(LIMIT);
  localparam logic [PROD_W-1:0] LIM_POS = PROD_W'(LIMIT - 1);

  logic signed [16:0] ext;
  logic               neg;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  quot;
  logic [7:0]         mag_c;

  always_comb begin
    ext  = {value[15], value};
    neg  = value[15];
    mag  = neg ? 17'(-ext) : 17'(ext);
    prod = PROD_W'(mag) * MULT_C;
    quot = prod >> SHIFT;
    if (neg) begin
      mag_c = (quot > LIM_NEG) ? 8'(LIMIT) : quot[7:0];
      pct   = $signed(8'd0 - mag_c);
    end else begin
      mag_c = (quot > LIM_POS) ? 8'(LIMIT - 1) : quot[7:0];
      pct   = $signed(mag_c);
    end
  end

endmodule

`default_nettype wire

// File: rtl/jdcc_event.sv
// event decode, state update and result formation for one word
// depends on jdcc_pkg and jdcc_scale
`default_nettype none

module jdcc_event #(
  parameter int unsigned AXIS_FULL_SCALE = jdcc_pkg::AXIS_FULL_SCALE_DEF
) (
  input  jdcc_pkg::in_item_t  item,
  input  jdcc_pkg::cfg_t      cfg,
  input  jdcc_pkg::state_t    st,
  output jdcc_pkg::state_t    st_nxt,
  output logic                emit,
  output jdcc_pkg::out_item_t res
);
  import jdcc_pkg::*;

  logic signed [15:0] r_m;
  logic [16:0]        mag_x, mag_y, mag_z, mag_r;
  logic signed [7:0]  pct_x, pct_y, pct_r, q_z;

  // rotation axis reads zero unless enabled
  assign r_m = st.rot_enabled ? item.axis_r : 16'sd0;

  jdcc_scale #(.DIVISOR(AXIS_FULL_SCALE), .LIMIT(PCT_LIMIT)) u_scale_x (
    .value(item.axis_x), .mag(mag_x), .pct(pct_x)
  );
  jdcc_scale #(.DIVISOR(AXIS_FULL_SCALE), .LIMIT(PCT_LIMIT)) u_scale_y (
    .value(item.axis_y), .mag(mag_y), .pct(pct_y)
  );
  jdcc_scale #(.DIVISOR(AXIS_FULL_SCALE), .LIMIT(PCT_LIMIT)) u_scale_r (
    .value(r_m), .mag(mag_r), .pct(pct_r)
  );
  jdcc_scale #(.DIVISOR(2 * AXIS_FULL_SCALE), .LIMIT(VERT_LIMIT)) u_scale_z (
    .value(item.axis_z), .mag(mag_z), .pct(q_z)
  );

  // movement against stored axes
  function automatic logic moved(input logic signed [15:0] a,
                                 input logic signed [15:0] b,
                                 input logic [15:0]        thr);
    logic signed [16:0] d;
    logic [16:0]        ad;
    d  = {a[15], a} - {b[15], b};
    ad = d[16] ? 17'(-d) : 17'(d);
    return ad > {1'b0, thr};
  endfunction

  logic any_moved;
  logic is_up, is_down, is_light, is_ren;
  logic use_dz, pass;
  logic [7:0] vsum;

  always_comb begin
    any_moved = moved(item.axis_x, st.last_x, cfg.change_threshold) ||
                moved(item.axis_y, st.last_y, cfg.change_threshold) ||
                moved(item.axis_z, st.last_z, cfg.change_threshold) ||
                moved(r_m,         st.last_r, cfg.change_threshold);
    is_up    = item.button_id == cfg.btn_z_up;
    is_down  = item.button_id == cfg.btn_z_down;
    is_light = item.button_id == cfg.btn_light;
    is_ren   = item.button_id == cfg.btn_r_enable;

    st_nxt = st;
    emit   = 1'b0;
    use_dz = 1'b1;
    pass   = 1'b0;

    unique case (item.mode)
      MODE_AXIS: begin
        if (any_moved) begin
          st_nxt.last_x = item.axis_x;
          st_nxt.last_y = item.axis_y;
          st_nxt.last_z = item.axis_z;
          st_nxt.last_r = r_m;
          emit = 1'b1;
        end
      end
      MODE_PRESS: begin
        // z up wins, then z down, light, rotation enable
        if (is_up) begin
          st_nxt.vertical_dir = DIR_NEG;
          emit   = 1'b1;
          use_dz = 1'b0;
        end else if (is_down) begin
          st_nxt.vertical_dir = DIR_POS;
          emit   = 1'b1;
          use_dz = 1'b0;
        end else if (is_light) begin
          st_nxt.light_on = ~st.light_on;
          st_nxt.last_x   = item.axis_x;
          st_nxt.last_y   = item.axis_y;
          st_nxt.last_z   = item.axis_z;
          st_nxt.last_r   = r_m;
          emit = 1'b1;
        end else if (is_ren) begin
          st_nxt.rot_enabled = 1'b1;
        end else begin
          pass = 1'b1;
          emit = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (is_up || is_down) begin
          st_nxt.vertical_dir = DIR_STOP;
          emit   = 1'b1;
          use_dz = 1'b0;
        end else if (is_ren) begin
          st_nxt.rot_enabled = 1'b0;
        end else begin
          pass = 1'b1;
          emit = 1'b1;
        end
      end
      default: ;  // unused mode, dropped
    endcase

    vsum = 8'($unsigned(q_z) + 8'(VERT_OFFSET));

    res = '0;
    if (pass) begin
      res.kind        = KIND_BUTTON;
      res.button_code = item.button_id;
    end else begin
      res.kind  = KIND_DRIVE;
      res.cmd_x = (use_dz && mag_x <= {2'b00, cfg.dead_zone}) ? 8'sd0 : pct_x;
      res.cmd_y = (use_dz && mag_y <= {2'b00, cfg.dead_zone}) ? 8'sd0 : pct_y;
      res.cmd_r = (use_dz && mag_r <= {2'b00, cfg.dead_zone}) ? 8'sd0 : pct_r;
      case (st_nxt.vertical_dir)
        DIR_POS: res.cmd_z = $signed(vsum);
        DIR_NEG: res.cmd_z = $signed(8'd0 - vsum);
        default: res.cmd_z = 8'sd0;
      endcase
      res.cam_cmd   = item.hat_pos;
      res.light_cmd = st_nxt.light_on;
    end
  end

  // z magnitude is not needed beyond the scaler
  logic unused_mag_z;
  assign unused_mag_z = ^mag_z;

endmodule

`default_nettype wire

// File: verif/joystick_drive_command_conditioner_core_tb.sv
// self-checking testbench for joystick_drive_command_conditioner_core
// holds its own event conditioner model; needs jdcc_pkg and the block's rtl only
`timescale 1ns / 100ps

module joystick_drive_command_conditioner_core_tb;
  import jdcc_pkg::*;

  localparam int FULL_SCALE = int'(AXIS_FULL_SCALE_DEF);
  localparam int PERCENT = 100;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;  // unmapped register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int DRAIN_CYCLES = 8;      // input and output registers, plus margin
  localparam int STALL_CYCLES = 120;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no word moved anywhere
  localparam int ITEMS_PER_PHASE = 66;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  joystick_drive_command_conditioner_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // events waiting for the driver, and commands the block still owes us
  in_item_t pending_events[$];
  out_item_t expected_words[$];

  int send_idle_pct = 34;
  int recv_idle_pct = 84;
  int errors = 0;
  int results_seen = 0;

  // ---------------------------------------------------------------------------
  // conditioner model: register copy and stored state
  // ---------------------------------------------------------------------------
  logic [4:0] sel_rot, sel_down, sel_light, sel_up;
  int dz_limit, move_limit;
  int last_x, last_y, last_z, last_r;
  int z_dir;           // -1 up, 0 stopped, +1 down
  bit lamp_on, rot_on;

  initial begin
    sel_rot = RST_BTN_R_ENABLE;
    sel_down = RST_BTN_Z_DOWN;
    sel_light = RST_BTN_LIGHT;
    sel_up = RST_BTN_Z_UP;
    dz_limit = int'(RST_DEAD_ZONE);
    move_limit = int'(RST_CHANGE_THRESHOLD);
    last_x = 0;
    last_y = 0;
    last_z = 0;
    last_r = 0;
    z_dir = 0;
    lamp_on = 1'b0;
    rot_on = 1'b0;
  end

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // percent of full scale, truncated toward zero
  function automatic int to_percent(int v);
    return clip(v * PERCENT / FULL_SCALE, -PERCENT, PERCENT - 1);
  endfunction

  function automatic out_item_t drive_cmd(int x, int y, int z, int r, logic [3:0] hat,
                                          bit use_dz);
    out_item_t w;
    int cx, cy, cr, q;
    cx = to_percent(x);
    cy = to_percent(y);
    cr = to_percent(r);
    if (use_dz) begin
      if (mag(x) <= dz_limit) cx = 0;
      if (mag(y) <= dz_limit) cy = 0;
      if (mag(r) <= dz_limit) cr = 0;
    end
    // throttle maps the full axis span onto 0..99 percent
    q = clip(z * PERCENT / (2 * FULL_SCALE), -50, 49);
    w = '0;
    w.kind = KIND_DRIVE;
    w.cmd_x = cx[7:0];
    w.cmd_y = cy[7:0];
    w.cmd_z = 8'(z_dir * (q + 50));
    w.cmd_r = cr[7:0];
    w.cam_cmd = hat;
    w.light_cmd = lamp_on;
    return w;
  endfunction

  function automatic out_item_t button_word(logic [4:0] b);
    out_item_t w;
    w = '0;
    w.kind = KIND_BUTTON;
    w.button_code = b;
    return w;
  endfunction

  // one event in, zero or one command out; updates the stored state
  task automatic condition_event(input in_item_t ev, output bit emits, output out_item_t w);
    int x, y, z, r;
    logic [4:0] b;
    x = ev.axis_x;
    y = ev.axis_y;
    z = ev.axis_z;
    r = rot_on ? int'(ev.axis_r) : 0;
    b = ev.button_id;
    emits = 1'b0;
    w = '0;
    case (ev.mode)
      MODE_AXIS: begin
        if (mag(x - last_x) > move_limit || mag(y - last_y) > move_limit ||
            mag(z - last_z) > move_limit || mag(r - last_r) > move_limit) begin
          last_x = x; last_y = y; last_z = z; last_r = r;
          w = drive_cmd(x, y, z, r, ev.hat_pos, 1'b1);
          emits = 1'b1;
        end
      end
      MODE_PRESS: begin
        // shared button numbers: up, then down, then light, then rotation
        if (b == sel_up) begin
          z_dir = -1;
          w = drive_cmd(x, y, z, r, ev.hat_pos, 1'b0);
          emits = 1'b1;
        end else if (b == sel_down) begin
          z_dir = 1;
          w = drive_cmd(x, y, z, r, ev.hat_pos, 1'b0);
          emits = 1'b1;
        end else if (b == sel_light) begin
          lamp_on = ~lamp_on;
          last_x = x; last_y = y; last_z = z; last_r = r;
          w = drive_cmd(x, y, z, r, ev.hat_pos, 1'b1);
          emits = 1'b1;
        end else if (b == sel_rot) begin
          rot_on = 1'b1;
        end else begin
          w = button_word(b);
          emits = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (b == sel_up || b == sel_down) begin
          z_dir = 0;
          w = drive_cmd(x, y, z, r, ev.hat_pos, 1'b0);
          emits = 1'b1;
        end else if (b == sel_rot) begin
          rot_on = 1'b0;
        end else begin
          w = button_word(b);
          emits = 1'b1;
        end
      end
      default: ; // unused mode leaves everything alone
    endcase
  endtask

  function automatic string describe(out_item_t w);
    return $sformatf("kind=%0d x=%0d y=%0d z=%0d r=%0d cam=%0d light=%0d button=%0d",
                     w.kind, w.cmd_x, w.cmd_y, w.cmd_z, w.cmd_r, w.cam_cmd,
                     w.light_cmd, w.button_code);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: pops events and offers them; predicts at the accepting edge
  // ---------------------------------------------------------------------------
  in_item_t offered;

  always @(posedge clk) begin
    bit emits;
    out_item_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        condition_event(offered, emits, w);
        if (emits) expected_words.push_back(w);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, offered.button_id, offered.hat_pos, offered.axis_r,
                       offered.axis_z, offered.axis_y, offered.axis_x};
          in_tuser <= offered.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted word and drives tready with hold-offs
  // ---------------------------------------------------------------------------
  int hold_left = 0;

  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser[0];
        got.cmd_x = out_tdata[7:0];
        got.cmd_y = out_tdata[15:8];
        got.cmd_z = out_tdata[23:16];
        got.cmd_r = out_tdata[31:24];
        got.cam_cmd = out_tdata[35:32];
        got.light_cmd = out_tdata[36];
        got.button_code = out_tdata[41:37];
        results_seen++;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %s", describe(got));
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on word %0d", results_seen);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      // two long stalls so the block backs up into its input
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (out_tvalid && out_tready && (results_seen == 40 || results_seen == 200)) begin
        out_tready <= 1'b0;
        hold_left <= STALL_CYCLES;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles where nothing moves
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  int gx = 0, gy = 0, gz = 0, gr = 0;   // axis values of the last generated event

  task automatic push_event(logic [1:0] mode, int x, int y, int z, int r, int hat, int btn);
    in_item_t ev;
    ev.mode = mode;
    ev.axis_x = x[15:0];
    ev.axis_y = y[15:0];
    ev.axis_z = z[15:0];
    ev.axis_r = r[15:0];
    ev.hat_pos = hat[3:0];
    ev.button_id = btn[4:0];
    pending_events.push_back(ev);
  endtask

  // mix of extremes, deadzone edges, threshold edges, no move and anything
  function automatic int pick_axis(int prev);
    int s;
    s = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: return clip(s * (dz_limit + $urandom_range(0, 2) - 1), -32768, 32767);
      3, 4, 5: return clip(prev + s * (move_limit + $urandom_range(0, 2) - 1), -32768, 32767);
      6: return prev;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic wiggle_axes();
    if ($urandom_range(0, 1)) gx = pick_axis(gx);
    if ($urandom_range(0, 1)) gy = pick_axis(gy);
    if ($urandom_range(0, 1)) gz = pick_axis(gz);
    if ($urandom_range(0, 1)) gr = pick_axis(gr);
  endtask

  task automatic push_motion();
    wiggle_axes();
    push_event(MODE_AXIS, gx, gy, gz, gr, $urandom_range(0, 15), $urandom_range(0, 31));
  endtask

  task automatic push_button(logic [1:0] mode, logic [4:0] b);
    wiggle_axes();
    push_event(mode, gx, gy, gz, gr, $urandom_range(0, 15), b);
  endtask

  function automatic logic [4:0] mapped_button();
    case ($urandom_range(0, 3))
      0: return sel_rot;
      1: return sel_down;
      2: return sel_light;
      default: return sel_up;
    endcase
  endfunction

  // held-button sequences with motion inside, plus single events and noise
  task automatic push_random(int count);
    int made, k;
    logic [4:0] b;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          k = $urandom_range(1, 4);
          repeat (k) push_motion();
          made += k;
        end
        4, 5, 6: begin
          b = mapped_button();
          k = $urandom_range(0, 3);
          push_button(MODE_PRESS, b);
          repeat (k) push_motion();
          push_button(MODE_RELEASE, b);
          made += k + 2;
        end
        7, 8: begin
          b = $urandom_range(0, 2) ? mapped_button() : 5'($urandom_range(0, 31));
          push_button($urandom_range(0, 1) ? MODE_PRESS : MODE_RELEASE, b);
          made++;
        end
        default: begin
          push_event(MODE_UNUSED, int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                     int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                     $urandom_range(0, 15), $urandom_range(0, 31));
          made++;
        end
      endcase
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BTN_R_ENABLE: sel_rot = val[4:0];
      REG_BTN_Z_DOWN: sel_down = val[4:0];
      REG_BTN_LIGHT: sel_light = val[4:0];
      REG_BTN_Z_UP: sel_up = val[4:0];
      REG_DEAD_ZONE: dz_limit = int'(val[14:0]);
      REG_CHANGE_THRESHOLD: move_limit = int'(val);
      default: ; // unmapped index, no effect
    endcase
  endtask

  task automatic program_regs(logic [15:0] rot, logic [15:0] down, logic [15:0] light,
                              logic [15:0] up, logic [15:0] dz, logic [15:0] thr);
    write_reg(REG_BTN_R_ENABLE, rot);
    write_reg(REG_BTN_Z_DOWN, down);
    write_reg(REG_BTN_LIGHT, light);
    write_reg(REG_BTN_Z_UP, up);
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_CHANGE_THRESHOLD, thr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // block idle: all events taken, all commands back, no-result events drained
  task automatic wait_drained();
    @(negedge clk);
    while (pending_events.size() != 0 || in_tvalid || expected_words.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed events under reset register values
    push_event(MODE_AXIS, 0, 0, 0, 0, 5, 0);                    // nothing moved
    push_event(MODE_AXIS, 32767, 0, 0, 0, 15, 31);              // full positive x
    push_event(MODE_AXIS, -32768, -32768, -32768, 32767, 0, 0); // full negative, r masked
    push_event(MODE_PRESS, 4000, -4001, 32767, 0, 3, 1);        // z down, no deadzone
    push_event(MODE_AXIS, 4000, -4001, 32767, -5, 9, 0);        // deadzone edges
    push_event(MODE_PRESS, -1, 1, -32768, 0, 6, 3);             // z up at bottom throttle
    push_event(MODE_RELEASE, 0, 0, 0, 0, 7, 3);                 // z up released
    push_event(MODE_PRESS, 0, 0, 0, 0, 8, 0);                   // rotation enable, silent
    push_event(MODE_AXIS, 0, 0, 0, -32768, 1, 0);               // full negative r
    push_event(MODE_AXIS, 0, 0, 0, 32767, 2, 0);                // full positive r
    push_event(MODE_PRESS, 100, 200, 300, 4001, 4, 2);          // light on, stores axes
    push_event(MODE_AXIS, 100, 200, 300, 4001, 4, 0);           // same as stored
    push_event(MODE_AXIS, 500, 200, 300, 4001, 4, 0);           // exactly at threshold
    push_event(MODE_AXIS, -301, 200, 300, 4001, 10, 0);         // one past threshold
    push_event(MODE_RELEASE, 0, 0, 0, 0, 11, 2);                // light release passes through
    push_event(MODE_PRESS, 1, 2, 3, 4, 12, 31);                 // unmapped button
    push_event(MODE_RELEASE, 1, 2, 3, 4, 13, 17);
    push_event(MODE_RELEASE, 0, 0, 0, 0, 14, 0);                // rotation disable, silent
    push_event(MODE_AXIS, -301, 200, 300, 30000, 14, 0);        // r masked back to zero
    push_event(MODE_UNUSED, -1, -1, -1, -1, 15, 31);            // ignored mode
    push_event(MODE_RELEASE, -32767, 32767, 100, 0, 0, 1);      // z down released
    push_event(MODE_PRESS, 0, 0, 0, 0, 0, 2);                   // light off
    push_event(MODE_PRESS, 0, 0, -32768, 0, 0, 1);
    push_event(MODE_PRESS, 0, 0, -32767, 0, 0, 1);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: ; // reset values
        1: program_regs(16'd31, 16'd0, 16'd15, 16'd30, 16'd0, 16'd0);
        // one button for every role, widest deadzone, threshold never reached
        2: program_regs(16'hFFE5, 16'h0005, 16'h8005, 16'h0025, 16'hFFFF, 16'hFFFF);
        // up and down share a number, light and rotation share another
        3: program_regs(16'd12, 16'd20, 16'd12, 16'd20, 16'd1000, 16'd50);
        default: begin
          if (phase == 4) begin
            write_reg(REG_SPARE_A, 16'($urandom));
            write_reg(REG_SPARE_B, 16'($urandom));
          end
          program_regs({11'($urandom), 5'($urandom_range(0, 31))},
                       {11'($urandom), 5'($urandom_range(0, 31))},
                       {11'($urandom), 5'($urandom_range(0, 31))},
                       {11'($urandom), 5'($urandom_range(0, 31))},
                       {1'($urandom), 15'($urandom_range(0, 12000))},
                       16'($urandom_range(0, 3000)));
        end
      endcase
      @(negedge clk);
      if (phase < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 84;
      end else if (phase < 6) begin
        send_idle_pct = 84;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      push_random(ITEMS_PER_PHASE);
      wait_drained();
    end

    if (errors == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
